@@ hw/rtl/bra_pkg.sv @@
package bra_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_SEARCH,
    ST_PROD,
    ST_SUM,
    ST_DONE
  } bra_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic init;
    logic step;
    logic pick;
    logic fallback;
    logic prod;
    logic sum;
  } bra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_last;
    logic tol0;
    logic in_range;
    logic hit;
  } bra_status_t;

  // Configuration register map.
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam logic [0:0]  REG_MAX_DEN = 1'b0;

  localparam int unsigned MAX_DEN_RESET = 1000000;

endpackage

@@ hw/rtl/best_rational_approximation_unit.sv @@
// Best rational approximation unit. A transaction starts when start_i is high while busy_o is
// low; value_q15_32_i is sampled at that edge. The result appears on numerator_o and
// denominator_o for exactly one cycle while done_o is high, and the receiver must take it in
// that cycle because the unit cannot be stalled. busy_o stays high from the accepted start
// through the done_o cycle, so transactions run one at a time. A transaction is a bit-serial
// multiply of the fraction by ten times the bound, a setup step, the Stern-Brocot mediant
// search at one step per cycle, skipped when the fraction is already within tolerance of
// zero, and finally the n*q product and the sum, each in its own state.
// The bound max_denominator is written over the APB-style port at byte address 0 and should
// only be changed while busy_o is low. A bound of zero is treated as one.
module best_rational_approximation_unit #(
  parameter int unsigned FRAC_BITS  = 32,
  parameter int unsigned INT_BITS   = 16,
  parameter int unsigned DENOM_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  // Command interface.
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]   value_q15_32_i,
  output logic                                   done_o,
  output logic signed [INT_BITS+DENOM_BITS-1:0]  numerator_o,
  output logic        [DENOM_BITS-1:0]           denominator_o,

  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [bra_pkg::ADDR_W-1:0]      paddr,
  input  logic        [bra_pkg::DATA_W-1:0]      pwdata,
  output logic        [bra_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready
);
  import bra_pkg::*;

  logic [DENOM_BITS-1:0] max_den_q, max_den_d;
  logic [0:0]            reg_idx;
  logic                  cfg_wr;
  bra_cmd_t              cmd;
  bra_status_t           status;

  // The register index is the word address; bytes within the word select nothing.
  assign reg_idx = paddr[2:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    max_den_d = max_den_q;
    if (cfg_wr && (reg_idx == REG_MAX_DEN)) begin
      max_den_d = pwdata[DENOM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_den_q <= DENOM_BITS'(MAX_DEN_RESET);
    end else begin
      max_den_q <= max_den_d;
    end
  end

  // Reads of an address beyond the register list return zero.
  assign prdata = (reg_idx == REG_MAX_DEN) ? DATA_W'(max_den_q) : '0;

  // The controller sequences the multiply, the mediant search and the final sum.
  bra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // The datapath keeps the search bounds and their scaled errors, so every step is an add.
  bra_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .INT_BITS   (INT_BITS),
    .DENOM_BITS (DENOM_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (value_q15_32_i),
    .max_den_i     (max_den_q),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

endmodule

@@ hw/rtl/bra_ctrl.sv @@
module bra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bra_pkg::bra_status_t status_i,
  output bra_pkg::bra_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import bra_pkg::*;

  bra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.mul_last) state_d = ST_INIT;
      end
      ST_INIT: begin
        state_d = status_i.tol0 ? ST_PROD : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!status_i.in_range || status_i.hit) state_d = ST_PROD;
      end
      ST_PROD: state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    done_o = 1'b0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:   cmd_o.load = start_i;
      ST_MUL:    cmd_o.mul_step = 1'b1;
      ST_INIT:   cmd_o.init = 1'b1;
      ST_SEARCH: begin
        if (!status_i.in_range) begin
          cmd_o.fallback = 1'b1;
        end else if (status_i.hit) begin
          cmd_o.pick = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_PROD:   cmd_o.prod = 1'b1;
      ST_SUM:    cmd_o.sum = 1'b1;
      ST_DONE:   done_o = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/bra_dp.sv @@
module bra_dp #(
  parameter int unsigned FRAC_BITS  = 32,
  parameter int unsigned INT_BITS   = 16,
  parameter int unsigned DENOM_BITS = 20
) (
  input  logic                                  clk_i,
  input  bra_pkg::bra_cmd_t                     cmd_i,
  output bra_pkg::bra_status_t                  status_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]  value_i,
  input  logic        [DENOM_BITS-1:0]          max_den_i,
  output logic signed [INT_BITS+DENOM_BITS-1:0] numerator_o,
  output logic        [DENOM_BITS-1:0]          denominator_o
);
  import bra_pkg::*;

  localparam int unsigned KW = DENOM_BITS + 4;
  localparam int unsigned CW = $clog2(KW);
  localparam int unsigned AW = FRAC_BITS + KW;
  localparam int unsigned MW = DENOM_BITS + 2;
  localparam int unsigned SW = FRAC_BITS + 2 * DENOM_BITS + 7;
  localparam int unsigned NW = INT_BITS + DENOM_BITS;

  logic        [FRAC_BITS-1:0]  f_q;
  logic signed [INT_BITS-1:0]   nu_q;
  logic        [DENOM_BITS-1:0] n_q;
  logic        [KW-1:0]         kfull_q, kshift_q;
  logic        [CW-1:0]         cnt_q;
  logic        [AW-1:0]         acc_q;
  logic        [MW-1:0]         a_q, b_q, c_q, d_q, t_q, u_q;
  logic signed [SW-1:0]         sa_q, sc_q, sm_q;
  logic        [DENOM_BITS-1:0] p_q, q_q;
  logic signed [NW-1:0]         prod_q, num_q;
  logic        [DENOM_BITS-1:0] den_q;

  logic        [DENOM_BITS-1:0] n_eff;
  logic        [KW-1:0]         k_load;
  logic        [AW-1:0]         acc_next;
  logic signed [SW-1:0]         acc_s, kf_s, u_s;
  logic signed [NW-1:0]         prod_full;
  logic        [MW-1:0]         n_ext;
  logic                         above;

  // A bound of zero behaves as a bound of one; K = 10 * N sets the tolerance.
  assign n_eff    = (max_den_i == '0) ? DENOM_BITS'(1) : max_den_i;
  assign k_load   = (KW'(n_eff) << 3) + (KW'(n_eff) << 1);
  assign acc_next = (acc_q << 1) + (kshift_q[KW-1] ? AW'(f_q) : AW'(0));

  assign acc_s = $signed(SW'(acc_q));
  assign kf_s  = $signed(SW'({kfull_q, {FRAC_BITS{1'b0}}}));
  assign u_s   = $signed(SW'({u_q, {FRAC_BITS{1'b0}}}));
  assign n_ext = MW'(n_q);

  // sm_q holds (f*u - t*2^F) * K for the current mediant t/u.
  assign above     = !sm_q[SW-1] && (sm_q != '0);
  // The floor times a denominator always fits in the numerator width.
  assign prod_full = nu_q * $signed({1'b0, q_q});

  assign status_o.mul_last = (cnt_q == '0);
  assign status_o.tol0     = (acc_q[AW-1:FRAC_BITS] == '0);
  assign status_o.in_range = (b_q <= n_ext) && (d_q <= n_ext);
  assign status_o.hit      = (sm_q < u_s) && (sm_q > -u_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q      <= value_i[FRAC_BITS-1:0];
      nu_q     <= value_i[INT_BITS+FRAC_BITS-1:FRAC_BITS];
      n_q      <= n_eff;
      kfull_q  <= k_load;
      kshift_q <= k_load;
      acc_q    <= '0;
      cnt_q    <= CW'(KW - 1);
    end else if (cmd_i.mul_step) begin
      acc_q    <= acc_next;
      kshift_q <= kshift_q << 1;
      cnt_q    <= cnt_q - 1'b1;
    end else if (cmd_i.init) begin
      sa_q <= acc_s;
      sc_q <= acc_s - kf_s;
      sm_q <= (acc_s <<< 1) - kf_s;
      a_q  <= MW'(0);
      b_q  <= MW'(1);
      c_q  <= MW'(1);
      d_q  <= MW'(1);
      t_q  <= MW'(1);
      u_q  <= MW'(2);
      p_q  <= '0;
      q_q  <= DENOM_BITS'(1);
    end else if (cmd_i.step) begin
      if (above) begin
        a_q  <= t_q;
        b_q  <= u_q;
        sa_q <= sm_q;
        t_q  <= t_q + c_q;
        u_q  <= u_q + d_q;
        sm_q <= sm_q + sc_q;
      end else begin
        c_q  <= t_q;
        d_q  <= u_q;
        sc_q <= sm_q;
        t_q  <= t_q + a_q;
        u_q  <= u_q + b_q;
        sm_q <= sm_q + sa_q;
      end
    end else if (cmd_i.pick) begin
      if (u_q <= n_ext) begin
        p_q <= t_q[DENOM_BITS-1:0];
        q_q <= u_q[DENOM_BITS-1:0];
      end else if (d_q > b_q) begin
        p_q <= c_q[DENOM_BITS-1:0];
        q_q <= d_q[DENOM_BITS-1:0];
      end else begin
        p_q <= a_q[DENOM_BITS-1:0];
        q_q <= b_q[DENOM_BITS-1:0];
      end
    end else if (cmd_i.fallback) begin
      if (b_q > n_ext) begin
        p_q <= c_q[DENOM_BITS-1:0];
        q_q <= d_q[DENOM_BITS-1:0];
      end else begin
        p_q <= a_q[DENOM_BITS-1:0];
        q_q <= b_q[DENOM_BITS-1:0];
      end
    end else if (cmd_i.prod) begin
      prod_q <= prod_full;
    end else if (cmd_i.sum) begin
      num_q <= prod_q + $signed(NW'(p_q));
      den_q <= q_q;
    end
  end

  assign numerator_o   = num_q;
  assign denominator_o = den_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned INT_BITS   = 16;
  localparam int unsigned DENOM_BITS = 20;
  localparam int unsigned VALUE_W    = INT_BITS + FRAC_BITS;
  localparam int unsigned NUM_W      = INT_BITS + DENOM_BITS;
  localparam int unsigned WIDE_W     = 128;

  // Register 0 (the bound) sits at byte address 0. The next word is unmapped, and
  // writes to it must leave the bound alone.
  localparam logic [bra_pkg::ADDR_W-1:0] MAX_DEN_ADDR =
    bra_pkg::ADDR_W'(4 * bra_pkg::REG_MAX_DEN);
  localparam logic [bra_pkg::ADDR_W-1:0] SPARE_ADDR   =
    bra_pkg::ADDR_W'(4 * (bra_pkg::REG_MAX_DEN + 1));

  // One expected answer, together with the value it was computed from.
  typedef struct {
    logic        [VALUE_W-1:0]    value;
    logic signed [NUM_W-1:0]      numerator;
    logic        [DENOM_BITS-1:0] denominator;
  } fraction_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start_i        = 1'b0;
  logic                         busy_o;
  logic signed [VALUE_W-1:0]    value_q15_32_i = '0;
  logic                         done_o;
  logic signed [NUM_W-1:0]      numerator_o;
  logic        [DENOM_BITS-1:0] denominator_o;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [bra_pkg::ADDR_W-1:0]   paddr          = '0;
  logic [bra_pkg::DATA_W-1:0]   pwdata         = '0;
  logic [bra_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Values waiting to be driven, and answers owed by the unit in arrival order.
  logic [VALUE_W-1:0]    queued_values[$];
  fraction_t             owed_fractions[$];
  // Our own copy of the bound register, updated when a write completes.
  logic [DENOM_BITS-1:0] bound_setting  = DENOM_BITS'(bra_pkg::MAX_DEN_RESET);
  int unsigned           values_issued  = 0;
  int unsigned           values_taken   = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           hold_cycles    = 0;
  bit                    was_taken      = 1'b0;
  bit                    gaps_enabled   = 1'b1;

  best_rational_approximation_unit #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS),
    .DENOM_BITS(DENOM_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_q15_32_i(value_q15_32_i),
    .done_o        (done_o),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Exact test of |frac - num/den| < 0.1/limit, with the fraction scaled by 2^FRAC_BITS.
  // Both sides are cross-multiplied so that the comparison stays in integers.
  function automatic bit near_fraction(input logic [FRAC_BITS-1:0] frac,
                                       input longint unsigned num, input longint unsigned den,
                                       input longint unsigned limit);
    logic [WIDE_W-1:0] scaled_frac;
    logic [WIDE_W-1:0] scaled_num;
    logic [WIDE_W-1:0] gap;
    scaled_frac = WIDE_W'(frac) * WIDE_W'(den);
    scaled_num  = WIDE_W'(num) << FRAC_BITS;
    gap = (scaled_frac >= scaled_num) ? scaled_frac - scaled_num : scaled_num - scaled_frac;
    return (gap * WIDE_W'(10 * limit)) < (WIDE_W'(den) << FRAC_BITS);
  endfunction

  // Best fraction with denominator at most the bound. The value is split into its floor
  // and a fraction; the fraction is located by a Stern-Brocot walk between 0/1 and 1/1,
  // and the floor times the chosen denominator is added back at the end.
  function automatic fraction_t best_fraction(input logic [VALUE_W-1:0] value,
                                              input logic [DENOM_BITS-1:0] bound);
    fraction_t                result;
    logic [FRAC_BITS-1:0]     frac;
    logic signed [INT_BITS-1:0] whole;
    longint unsigned          limit;
    longint unsigned          lo_num, lo_den, hi_num, hi_den, mid_num, mid_den, p, q;
    logic signed [63:0]       scaled;
    bit                       settled;
    frac   = value[FRAC_BITS-1:0];
    whole  = value[VALUE_W-1:FRAC_BITS];
    limit  = (bound == 0) ? 1 : bound;   // a bound of zero acts as one
    lo_num = 0;
    lo_den = 1;
    hi_num = 1;
    hi_den = 1;
    p      = 0;
    q      = 1;
    // A fraction already within tolerance of zero gives the floor over one.
    settled = near_fraction(frac, 0, 1, limit);
    while (!settled && lo_den <= limit && hi_den <= limit) begin
      mid_num = lo_num + hi_num;
      mid_den = lo_den + hi_den;
      if (near_fraction(frac, mid_num, mid_den, limit)) begin
        if (mid_den <= limit) begin
          p = mid_num;
          q = mid_den;
        end else if (hi_den > lo_den) begin
          p = hi_num;
          q = hi_den;
        end else begin
          p = lo_num;
          q = lo_den;
        end
        settled = 1'b1;
      end else if ((WIDE_W'(frac) * WIDE_W'(mid_den)) > (WIDE_W'(mid_num) << FRAC_BITS)) begin
        lo_num = mid_num;
        lo_den = mid_den;
      end else begin
        hi_num = mid_num;
        hi_den = mid_den;
      end
    end
    // The walk ran out: keep whichever bound still has a legal denominator.
    if (!settled) begin
      if (lo_den > limit) begin
        p = hi_num;
        q = hi_den;
      end else begin
        p = lo_num;
        q = lo_den;
      end
    end
    scaled             = longint'(whole) * longint'(q) + longint'(p);
    result.value       = value;
    result.numerator   = NUM_W'(scaled);
    result.denominator = DENOM_BITS'(q);
    return result;
  endfunction

  // Random value. Half are fully random; the rest put the fraction close to zero or
  // close to one, where the mediant walk is longest, or make it exactly zero.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] value;
    value = VALUE_W'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1: begin
        value[FRAC_BITS-1:0] = ~FRAC_BITS'($urandom_range(0, 1 << 20));
      end
      2, 3: begin
        value[FRAC_BITS-1:0] = FRAC_BITS'($urandom_range(0, 1 << 20));
      end
      4: begin
        value[FRAC_BITS-1:0] = '0;
      end
      default: begin
      end
    endcase
    return value;
  endfunction

  // Driver. Presents the next queued value at the falling edge and holds it until the
  // unit takes the transaction; after a transaction it may idle for a random burst.
  always @(negedge clk_i) begin : drive_values
    logic               next_start;
    logic [VALUE_W-1:0] next_value;
    next_start = start_i;
    next_value = value_q15_32_i;
    if (!rst_ni) begin
      next_start = 1'b0;
    end else if (!start_i || was_taken) begin
      if (was_taken) begin
        was_taken = 1'b0;
        if (gaps_enabled && $urandom_range(0, 2) == 0) begin
          hold_cycles = $urandom_range(1, 13);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        next_start = 1'b0;
      end else if (queued_values.size() > 0) begin
        next_start = 1'b1;
        next_value = queued_values.pop_front();
      end else begin
        next_start = 1'b0;
      end
    end
    start_i        <= next_start;
    value_q15_32_i <= next_value;
  end

  // Monitor. At each rising edge an accepted transaction adds its expected answer, and
  // a result under done_o is checked against the oldest answer still owed.
  always @(posedge clk_i) begin : watch_results
    fraction_t want;
    if (rst_ni && start_i && !busy_o) begin
      owed_fractions.push_back(best_fraction(value_q15_32_i, bound_setting));
      values_taken++;
      was_taken = 1'b1;
    end
    if (rst_ni && done_o) begin
      if (owed_fractions.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %0d/%0d",
                 $time, numerator_o, denominator_o);
        mismatch_count++;
      end else begin
        want = owed_fractions.pop_front();
        if (numerator_o !== want.numerator) begin
          $display("%0t: numerator mismatch for value %h: expected %0d, got %0d",
                   $time, want.value, want.numerator, numerator_o);
          mismatch_count++;
        end
        if (denominator_o !== want.denominator) begin
          $display("%0t: denominator mismatch for value %h: expected %0d, got %0d",
                   $time, want.value, want.denominator, denominator_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic queue_value(input logic [VALUE_W-1:0] value);
    queued_values.push_back(value);
    values_issued++;
  endtask

  // Waits until every queued value has been taken and answered and the unit is idle.
  // This is also where the sender pauses for all outstanding results.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (values_taken != values_issued || owed_fractions.size() != 0 || busy_o);
  endtask

  // Setup cycle, then access cycle until pready; the register updates at that edge.
  task automatic write_reg(input logic [bra_pkg::ADDR_W-1:0] addr,
                           input logic [bra_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (addr == MAX_DEN_ADDR) begin
      bound_setting = data[DENOM_BITS-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads the bound back and compares it with our copy.
  task automatic check_bound_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_DEN_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (prdata !== bra_pkg::DATA_W'(bound_setting)) begin
      $display("%0t: bound readback mismatch: expected %0d, got %0d",
               $time, bound_setting, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [DENOM_BITS-1:0] bound;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset bound: integer extremes, a fraction within tolerance of zero, halves of
    // both signs, the most negative floor, one third and pi (a long mediant walk).
    check_bound_readback();
    queue_value(48'h0000_0000_0000);
    queue_value(48'h7FFF_0000_0000);
    queue_value(48'h8000_0000_0000);
    queue_value(48'h0000_0000_0001);
    queue_value(48'h0000_8000_0000);
    queue_value(48'hFFFF_8000_0000);
    queue_value(48'h0003_243F_6A89);
    queue_value(48'h8000_4000_0000);
    queue_value(48'h0000_5555_5555);
    wait_idle();

    // Smallest bound: a fraction just short of one must round up to the next integer.
    write_reg(MAX_DEN_ADDR, 1);
    check_bound_readback();
    queue_value(48'h0005_FFFF_FFFF);
    queue_value(48'h7FFF_FFFF_FFFF);
    queue_value(48'h0000_8000_0000);
    queue_value(48'hFFFF_CCCC_CCCD);
    wait_idle();

    // A zero bound behaves as a bound of one.
    write_reg(MAX_DEN_ADDR, 0);
    check_bound_readback();
    queue_value(48'h8000_FFFF_FFFF);
    queue_value(48'h0000_1999_999A);
    wait_idle();

    // Writes to the unmapped word are dropped. Then the largest bound, written with all
    // data bits set, with values whose walks stay short.
    write_reg(SPARE_ADDR, $urandom);
    check_bound_readback();
    write_reg(MAX_DEN_ADDR, '1);
    check_bound_readback();
    queue_value(48'h0000_0000_0000);
    queue_value(48'h0000_8000_0000);
    queue_value(48'h0001_0000_0001);
    queue_value(48'h7FFF_AAAA_AAAB);
    queue_value(48'hFFFC_DBC0_9577);
    wait_idle();

    // Upper data bits are ignored; the bound becomes seven.
    write_reg(MAX_DEN_ADDR, {12'($urandom_range(1, 4095)), 20'd7});
    check_bound_readback();
    repeat (3) queue_value(random_value());
    wait_idle();

    // Random phases, one tiny bound first and moderate ones after, to keep the walks
    // short. The last phase runs without idle gaps.
    for (int phase = 0; phase < 5; phase++) begin
      bound = (phase == 0) ? DENOM_BITS'($urandom_range(1, 15))
                           : DENOM_BITS'($urandom_range(16, 4095));
      write_reg(MAX_DEN_ADDR, bra_pkg::DATA_W'(bound));
      check_bound_readback();
      if (phase == 4) begin
        gaps_enabled = 1'b0;
      end
      repeat (20) queue_value(random_value());
      wait_idle();
    end

    repeat (DENOM_BITS + 8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Covers the slowest legal run, where every value at a large bound walks the full
  // bound, several times over.
  initial begin : run_limit
    #300ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ best_rational_approximation_unit.f @@
hw/rtl/bra_pkg.sv
hw/rtl/bra_ctrl.sv
hw/rtl/bra_dp.sv
hw/rtl/best_rational_approximation_unit.sv
bench/testbench.sv
